@@ sv/sewb_pkg.sv @@
// Shared constants and types for the seamless edge weld blend.
package sewb_pkg;
  localparam int unsigned MAX_HALF = 4096;
  localparam int unsigned NUM_W    = 45;   // signed numerator/denominator width
  localparam int unsigned DIV_LAT  = 10;   // divider register stages
  localparam int unsigned FRONT    = 5;    // weight and product stages
  localparam int unsigned LAT      = FRONT + DIV_LAT + 1;

  localparam logic [2:0] REG_HALF_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HALF_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WIDTH_ODD   = 3'd2;
  localparam logic [2:0] REG_CH_COUNT    = 3'd3;
  localparam logic [2:0] REG_ALPHA_MODE  = 3'd4;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [7:0] pix_t;
endpackage

@@ sv/sewb_div.sv @@
// Pipelined truncating divider with saturation to 0..255.
module sewb_div import sewb_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  num_t num_i,
  input  num_t den_i,
  output pix_t quo_o
);
  localparam int unsigned RW = NUM_W + 8;

  logic [RW-1:0]    rem_q [0:9];
  logic [NUM_W-1:0] den_q [0:9];
  logic [7:0]       quo_q [0:9];
  logic             neg_q [0:9];
  logic             sat_q [0:9];

  num_t numn, denn;
  logic [RW-1:0] dsh8;
  logic [RW-1:0] dsh [0:7];
  logic          ge  [0:7];

  always_comb begin
    numn = (den_i < 0) ? -num_i : num_i;
    denn = (den_i < 0) ? -den_i : den_i;
    dsh8 = {den_q[0], 8'd0};
    // one quotient bit per stage, msb first
    for (int j = 0; j < 8; j++) begin
      dsh[j] = {8'd0, den_q[j+1]} << (7 - j);
      ge[j]  = rem_q[j+1] >= dsh[j];
    end
  end

  // stage 0: sign normalize, stage 1: overflow check, then the bit stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= numn < 0;
      rem_q[0] <= (numn < 0) ? '0 : {8'd0, numn};
      den_q[0] <= denn;
      quo_q[0] <= '0;
      sat_q[0] <= 1'b0;
      neg_q[1] <= neg_q[0];
      rem_q[1] <= rem_q[0];
      den_q[1] <= den_q[0];
      quo_q[1] <= '0;
      sat_q[1] <= rem_q[0] >= dsh8;
      for (int j = 0; j < 8; j++) begin
        neg_q[j+2] <= neg_q[j+1];
        sat_q[j+2] <= sat_q[j+1];
        den_q[j+2] <= den_q[j+1];
        rem_q[j+2] <= ge[j] ? rem_q[j+1] - dsh[j] : rem_q[j+1];
        quo_q[j+2] <= quo_q[j+1] | (ge[j] ? 8'(8'd1 << (7 - j)) : 8'd0);
      end
    end
  end

  assign quo_o = neg_q[9] ? 8'd0 : (sat_q[9] ? 8'd255 : quo_q[9]);
endmodule

@@ sv/seamless_edge_weld_blend.sv @@
// Top level of the seamless edge weld blend pipeline.
// Takes one pixel pair per cycle while in_stall_o is low and returns one welded pixel per beat.
// The pipe runs through the weight stages (position terms, the two weight
// products, tie resolution, channel products, numerator sums) followed by a ten-stage
// restoring divider, one per channel (sign normalize, overflow check, then one quotient
// bit per stage over eight stages), and an
// output register. The whole pipe advances as one: it moves whenever the output register is
// empty or being taken, so a stall on the output freezes every stage and nothing is lost.
// Configuration must only be written while the pipe is empty.
module seamless_edge_weld_blend import sewb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        right_pass_i,
  input  logic [11:0] col_i,
  input  logic [11:0] row_i,
  input  logic [7:0]  first_ch0_i,
  input  logic [7:0]  first_ch1_i,
  input  logic [7:0]  first_ch2_i,
  input  logic [7:0]  first_ch3_i,
  input  logic [7:0]  second_ch0_i,
  input  logic [7:0]  second_ch1_i,
  input  logic [7:0]  second_ch2_i,
  input  logic [7:0]  second_ch3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_ch0_o,
  output logic [7:0]  out_ch1_o,
  output logic [7:0]  out_ch2_o,
  output logic [7:0]  out_ch3_o,
  output logic        colour_written_o
);
  // config registers
  logic [12:0] hw_q, hh_q;
  logic        odd_q, amode_q;
  logic [2:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= 13'd2; hh_q <= 13'd2; odd_q <= 1'b0; cnt_q <= 3'd3; amode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF_WIDTH:  hw_q    <= cfg_data_i;
        REG_HALF_HEIGHT: hh_q    <= cfg_data_i;
        REG_WIDTH_ODD:   odd_q   <= cfg_data_i[0];
        REG_CH_COUNT:    cnt_q   <= cfg_data_i[2:0];
        REG_ALPHA_MODE:  amode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [12:0] hw, hh;
  logic [2:0]  n;
  logic [1:0]  ai;          // alpha channel index
  always_comb begin
    hw = (hw_q > 13'(MAX_HALF)) ? 13'(MAX_HALF) : hw_q;
    hh = (hh_q > 13'(MAX_HALF)) ? 13'(MAX_HALF) : hh_q;
    n  = (cnt_q > 3'd4) ? 3'd4 : cnt_q;
    ai = 2'(n - 3'd1);
  end

  // global advance
  logic [LAT-1:0] v_q;
  logic adv;
  assign adv        = !v_q[LAT-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[LAT-2:0], in_valid_i};
  end

  pix_t s1_in [4], s2_in [4];
  assign s1_in = '{first_ch0_i, first_ch1_i, first_ch2_i, first_ch3_i};
  assign s2_in = '{second_ch0_i, second_ch1_i, second_ch2_i, second_ch3_i};

  // stage 1: distances to the quadrant edge and corner ties
  logic [12:0]        x;
  logic signed [13:0] dx, dy, a1, b1;
  logic signed [13:0] a_q, b_q, ca_q, cb_q;
  logic               t1_q, t0_q;
  pix_t               s1_1q [4], s2_1q [4];

  always_comb begin
    x  = 13'(col_i) + 13'(right_pass_i && !odd_q);
    dx = $signed({1'b0, x}) - $signed({1'b0, hw});
    dy = $signed({2'b0, row_i}) - $signed({1'b0, hh});
    a1 = ((dx < 0) ? -dx : dx) - 14'sd1;
    b1 = ((dy < 0) ? -dy : dy) - 14'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= a1;
      b_q   <= b1;
      ca_q  <= $signed({1'b0, hw}) - 14'sd1 - a1;
      cb_q  <= $signed({1'b0, hh}) - 14'sd1 - b1;
      t1_q  <= (a1 <= 0) && (b1 >= $signed({1'b0, hh}) - 14'sd1);
      t0_q  <= (a1 >= $signed({1'b0, hw}) - 14'sd1) && (b1 <= 0);
      s1_1q <= s1_in;
      s2_1q <= s2_in;
    end
  end

  // stage 2: raw weights, alpha premultiply
  logic signed [26:0] pr_q, qr_q;
  logic               t1_2q, t0_2q;
  pix_t               s1_2q [4], s2_2q [4];
  logic [15:0]        pa1_2q [4], pa2_2q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q  <= 27'(a_q * b_q);
      qr_q  <= 27'(ca_q * cb_q);
      t1_2q <= t1_q;
      t0_2q <= t0_q;
      s1_2q <= s1_1q;
      s2_2q <= s2_1q;
      for (int i = 0; i < 4; i++) begin
        pa1_2q[i] <= s1_1q[i] * s1_1q[ai];
        pa2_2q[i] <= s2_1q[i] * s2_1q[ai];
      end
    end
  end

  // stage 3: tie and degenerate resolution
  logic signed [26:0] p_q, q_q, d_q;
  pix_t               s1_3q [4], s2_3q [4];
  logic [15:0]        pa1_3q [4], pa2_3q [4];
  logic signed [26:0] pn, qn;

  always_comb begin
    if (t1_2q) begin
      pn = 27'sd0; qn = 27'sd1;
    end else if (t0_2q) begin
      pn = 27'sd1; qn = 27'sd0;
    end else if (pr_q + qr_q == 27'sd0) begin
      pn = 27'sd0; qn = 27'sd1;
    end else begin
      pn = pr_q; qn = qr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q    <= pn;
      q_q    <= qn;
      d_q    <= pn + qn;
      s1_3q  <= s1_2q;
      s2_3q  <= s2_2q;
      pa1_3q <= pa1_2q;
      pa2_3q <= pa2_2q;
    end
  end

  // stage 4: weighted channel products
  num_t qs1_q [4], ps2_q [4], qa1_q [4], pa2w_q [4];
  num_t d4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d4_q <= NUM_W'(d_q);
      for (int i = 0; i < 4; i++) begin
        qs1_q[i]  <= NUM_W'(q_q * $signed({1'b0, s1_3q[i]}));
        ps2_q[i]  <= NUM_W'(p_q * $signed({1'b0, s2_3q[i]}));
        qa1_q[i]  <= NUM_W'(q_q * $signed({1'b0, pa1_3q[i]}));
        pa2w_q[i] <= NUM_W'(p_q * $signed({1'b0, pa2_3q[i]}));
      end
    end
  end

  // stage 5: numerator and denominator per channel
  num_t num_q [4], den_q [4];
  num_t na;
  assign na = qs1_q[ai] + ps2_q[ai];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (amode_q && (2'(i) < ai)) begin
          num_q[i] <= qa1_q[i] + pa2w_q[i];
          den_q[i] <= na;
        end else begin
          num_q[i] <= qs1_q[i] + ps2_q[i];
          den_q[i] <= d4_q;
        end
      end
    end
  end

  pix_t quo [4];
  for (genvar c = 0; c < 4; c++) begin : g_div
    sewb_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num_q[c]),
      .den_i (den_q[c]),
      .quo_o (quo[c])
    );
  end

  // output register: channel masking and alpha-zero handling
  pix_t out_q [4];
  logic cw_q;
  logic azero;
  assign azero = amode_q && (n != 3'd0) && (quo[ai] == 8'd0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) >= n || (azero && 2'(i) < ai)) out_q[i] <= 8'd0;
        else out_q[i] <= quo[i];
      end
      cw_q <= !azero;
    end
  end

  assign out_valid_o      = v_q[LAT-1];
  assign out_ch0_o        = out_q[0];
  assign out_ch1_o        = out_q[1];
  assign out_ch2_o        = out_q[2];
  assign out_ch3_o        = out_q[3];
  assign colour_written_o = cw_q;

  a_stall_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to output hold");
  a_cw_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !colour_written_o |-> amode_q)
    else $error("colour suppressed outside alpha mode");
  a_cw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !colour_written_o |-> out_ch0_o == 8'd0)
    else $error("colour channel written with zero alpha");
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (n < 3'd4) |-> out_ch3_o == 8'd0)
    else $error("unused channel not cleared");
endmodule
